// ===== design/kcl_pkg.sv =====
package kcl_pkg;

  // Configuration register indexes
  localparam logic CFG_FAIL_LIMIT  = 1'b0;
  localparam logic CFG_PULSE_TICKS = 1'b1;

  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [7:0]  FAIL_LIMIT_RST  = 8'd3;
  localparam logic [15:0] PULSE_TICKS_RST = 16'd2000;
  localparam logic [7:0]  FAIL_SAT        = 8'hFF;

  // Key codes
  localparam logic [3:0] KEY_DIGIT_MIN = 4'd0;
  localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [3:0] KEY_CHANGE    = 4'd10;
  localparam logic [3:0] KEY_CLOSE     = 4'd11;

  // Factory code digits, alternating over the positions
  localparam logic [3:0] CODE_EVEN_DIGIT = 4'd6;
  localparam logic [3:0] CODE_ODD_DIGIT  = 4'd7;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_OLD    = 2'd1,
    MODE_NEW    = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_DIGIT   = 3'd1,
    EV_UNLOCK  = 3'd2,
    EV_WRONG   = 3'd3,
    EV_LOCKOUT = 3'd4,
    EV_OLD_OK  = 3'd5,
    EV_CHANGED = 3'd6,
    EV_SET     = 3'd7
  } event_e;

  typedef struct packed {
    event_e      ev;
    logic [1:0]  digits;
    mode_e       mode;
    logic [7:0]  fails;
    logic        locked;
    logic        relay;
    logic        buzzer;
    logic        led;
  } res_t;

endpackage

// ===== design/keypad_code_lock_controller.sv =====
// Throughput: one input transfer per cycle while the skid entry is free; all key
// handling, code compare and pulse timing is done in a single pass into the state
// and result registers. A two-entry output buffer (result register plus skid)
// keeps input open for one more transfer while the output is stalled. Reset
// (async, active low) restores code 6,7,.., clears entry, positions, failures,
// lock and drives, and loads register defaults.
module keypad_code_lock_controller #(
  parameter int unsigned CODE_DIGITS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [kcl_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // key input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          key_valid_i,
  input  logic [3:0]                    key_code_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    event_res_o,
  output logic [1:0]                    digits_entered_o,
  output logic [1:0]                    mode_o,
  output logic [7:0]                    fail_count_o,
  output logic                          locked_o,
  output logic                          relay_on_o,
  output logic                          buzzer_on_o,
  output logic                          led_on_o
);

  // Position counters wrap at CODE_DIGITS, so they only need to hold the last index.
  localparam int unsigned PosW = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam logic [PosW-1:0] LastPos = PosW'(CODE_DIGITS - 1);
  localparam int unsigned PulseW = 17;

  typedef logic [CODE_DIGITS-1:0][3:0] code_t;

  // Configuration registers
  logic [7:0]  fail_limit_q;
  logic [15:0] pulse_ticks_q;

  // Lock state
  code_t                stored_q, stored_d;
  code_t                entry_q, entry_d;
  logic [PosW-1:0]      norm_pos_q, norm_pos_d;
  logic [PosW-1:0]      set_pos_q, set_pos_d;
  kcl_pkg::mode_e       mode_q, mode_d;
  logic [7:0]           fail_q, fail_d;
  logic                 lock_q, lock_d;
  logic [PulseW-1:0]    pulse_q, pulse_d;
  logic                 buz_q, buz_d;
  logic                 led_q, led_d;
  logic                 relay_q, relay_d;

  // Output buffer: result register plus one skid entry
  kcl_pkg::res_t out_q, skid_q, res_d;
  logic          out_valid_q, skid_valid_q;

  logic              in_xfer, out_xfer;
  kcl_pkg::event_e   ev;
  logic              fail_hit;
  logic [PulseW-1:0] pulse_mid, pulse_inc;
  logic [PosW-1:0]   cur_pos;
  logic [PosW+1:0]   pos_ext;

  // Input stays open as long as the skid entry is free.
  assign in_ready_o = !skid_valid_q;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_xfer   = out_valid_q && out_ready_i;

  // A failed entry locks once the earlier count reaches limit minus one.
  assign fail_hit = ({1'b0, fail_q} + 9'd1) >= {1'b0, fail_limit_q};

  always_comb begin
    stored_d   = stored_q;
    entry_d    = entry_q;
    norm_pos_d = norm_pos_q;
    set_pos_d  = set_pos_q;
    mode_d     = mode_q;
    fail_d     = fail_q;
    lock_d     = lock_q;
    buz_d      = buz_q;
    led_d      = led_q;
    relay_d    = relay_q;
    pulse_mid  = pulse_q;
    ev         = kcl_pkg::EV_NONE;

    if (in_xfer && key_valid_i && !lock_q) begin
      if (key_code_i inside {[kcl_pkg::KEY_DIGIT_MIN:kcl_pkg::KEY_DIGIT_MAX]}) begin
        ev = kcl_pkg::EV_DIGIT;
        if (mode_q == kcl_pkg::MODE_NORMAL) begin
          entry_d[norm_pos_q] = key_code_i;
          norm_pos_d = norm_pos_q + PosW'(1);
          if (norm_pos_q == LastPos) begin
            norm_pos_d = '0;
            if (entry_d == stored_q) begin
              // unlock: start the buzzer pulse, forgive earlier failures
              buz_d     = 1'b1;
              pulse_mid = PulseW'(1);
              fail_d    = '0;
              ev        = kcl_pkg::EV_UNLOCK;
            end else begin
              buz_d = 1'b0;
              ev    = fail_hit ? kcl_pkg::EV_LOCKOUT : kcl_pkg::EV_WRONG;
              if (fail_hit) begin
                lock_d  = 1'b1;
                relay_d = 1'b1;
              end
              if (fail_q != kcl_pkg::FAIL_SAT) fail_d = fail_q + 8'd1;
            end
          end
        end else begin
          entry_d[set_pos_q] = key_code_i;
          set_pos_d = set_pos_q + PosW'(1);
          if (set_pos_q == LastPos) begin
            set_pos_d = '0;
            if (mode_q == kcl_pkg::MODE_NEW) begin
              // commit the new code and flash the LED
              stored_d  = entry_d;
              mode_d    = kcl_pkg::MODE_NORMAL;
              led_d     = 1'b1;
              pulse_mid = PulseW'(1);
              ev        = kcl_pkg::EV_CHANGED;
            end else if (entry_d == stored_q) begin
              mode_d = kcl_pkg::MODE_NEW;
              ev     = kcl_pkg::EV_OLD_OK;
            end else begin
              // old code wrong: stay waiting for the old code
              ev = fail_hit ? kcl_pkg::EV_LOCKOUT : kcl_pkg::EV_WRONG;
              if (fail_hit) begin
                lock_d  = 1'b1;
                relay_d = 1'b1;
              end
              if (fail_q != kcl_pkg::FAIL_SAT) fail_d = fail_q + 8'd1;
            end
          end
        end
      end else if (key_code_i == kcl_pkg::KEY_CHANGE) begin
        mode_d    = kcl_pkg::MODE_OLD;
        set_pos_d = '0;
        ev        = kcl_pkg::EV_SET;
      end else if (key_code_i == kcl_pkg::KEY_CLOSE) begin
        buz_d = 1'b0;
        ev    = kcl_pkg::EV_SET;
      end
    end

    // Pulse timer advances once per transfer, also while locked.
    pulse_inc = pulse_mid + PulseW'(1);
    pulse_d   = pulse_mid;
    if (in_xfer && (pulse_mid != '0)) begin
      pulse_d = pulse_inc;
      if (pulse_inc > {1'b0, pulse_ticks_q}) begin
        buz_d   = 1'b0;
        led_d   = 1'b0;
        pulse_d = '0;
      end
    end
  end

  // Assemble the result from the next state.
  always_comb begin
    cur_pos      = (mode_d == kcl_pkg::MODE_NORMAL) ? norm_pos_d : set_pos_d;
    pos_ext      = {2'b00, cur_pos};
    res_d.ev     = ev;
    res_d.digits = pos_ext[1:0];
    res_d.mode   = mode_d;
    res_d.fails  = fail_d;
    res_d.locked = lock_d;
    res_d.relay  = relay_d;
    res_d.buzzer = buz_d;
    res_d.led    = led_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_limit_q  <= kcl_pkg::FAIL_LIMIT_RST;
      pulse_ticks_q <= kcl_pkg::PULSE_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kcl_pkg::CFG_FAIL_LIMIT:  fail_limit_q  <= cfg_wdata_i[7:0];
        kcl_pkg::CFG_PULSE_TICKS: pulse_ticks_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CODE_DIGITS; i++) begin
        stored_q[i] <= (i % 2 == 1) ? kcl_pkg::CODE_ODD_DIGIT : kcl_pkg::CODE_EVEN_DIGIT;
      end
      entry_q    <= '0;
      norm_pos_q <= '0;
      set_pos_q  <= '0;
      mode_q     <= kcl_pkg::MODE_NORMAL;
      fail_q     <= '0;
      lock_q     <= 1'b0;
      pulse_q    <= '0;
      buz_q      <= 1'b0;
      led_q      <= 1'b0;
      relay_q    <= 1'b0;
    end else if (in_xfer) begin
      stored_q   <= stored_d;
      entry_q    <= entry_d;
      norm_pos_q <= norm_pos_d;
      set_pos_q  <= set_pos_d;
      mode_q     <= mode_d;
      fail_q     <= fail_d;
      lock_q     <= lock_d;
      pulse_q    <= pulse_d;
      buz_q      <= buz_d;
      led_q      <= led_d;
      relay_q    <= relay_d;
    end
  end

  // Output buffer control: fill the result register first, spill to skid when
  // it stays occupied, and drain skid into the result register on a transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_xfer || !out_valid_q) begin
        out_valid_q  <= skid_valid_q || in_xfer;
        skid_valid_q <= 1'b0;
      end else if (in_xfer) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_xfer || !out_valid_q) begin
      out_q <= skid_valid_q ? skid_q : res_d;
    end
    if (in_xfer && !skid_valid_q) begin
      skid_q <= res_d;
    end
  end

  // Drive the result ports.
  always_comb begin
    out_valid_o      = out_valid_q;
    event_res_o      = out_q.ev;
    digits_entered_o = out_q.digits;
    mode_o           = out_q.mode;
    fail_count_o     = out_q.fails;
    locked_o         = out_q.locked;
    relay_on_o       = out_q.relay;
    buzzer_on_o      = out_q.buzzer;
    led_on_o         = out_q.led;
  end

  // Lockout holds until reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni) lock_q |=> lock_q)
    else $error("lockout cleared without reset");

  // Buzzer and LED are only on while the pulse timer runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pulse_q == '0) |-> (!buz_q && !led_q))
    else $error("indicator on with pulse timer idle");

  // The skid entry is only used behind a full result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_valid_q |-> out_valid_q)
    else $error("skid entry held with empty result register");

  // A reported lockout always drives the relay.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && locked_o) |-> relay_on_o)
    else $error("locked result without relay drive");

endmodule

// ===== verif/tb_keypad_code_lock_controller.sv =====
module tb_keypad_code_lock_controller;

  localparam int unsigned CODE_LEN = 4;
  localparam int unsigned RANDOM_PER_PHASE = 300;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic                           cfg_idx_i;
  logic [kcl_pkg::CFG_DATA_W-1:0] cfg_wdata_i;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic                           key_valid_i;
  logic [3:0]                     key_code_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic [2:0]                     event_res_o;
  logic [1:0]                     digits_entered_o;
  logic [1:0]                     mode_o;
  logic [7:0]                     fail_count_o;
  logic                           locked_o;
  logic                           relay_on_o;
  logic                           buzzer_on_o;
  logic                           led_on_o;

  keypad_code_lock_controller #(.CODE_DIGITS(CODE_LEN)) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .key_valid_i      (key_valid_i),
    .key_code_i       (key_code_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .event_res_o      (event_res_o),
    .digits_entered_o (digits_entered_o),
    .mode_o           (mode_o),
    .fail_count_o     (fail_count_o),
    .locked_o         (locked_o),
    .relay_on_o       (relay_on_o),
    .buzzer_on_o      (buzzer_on_o),
    .led_on_o         (led_on_o)
  );

  // Shadow copy of the lock: code, shared entry buffer, per-mode positions,
  // failure count, lock flag, pulse timer and the three drives.
  logic [CODE_LEN-1:0][3:0] code_store =
    {kcl_pkg::CODE_ODD_DIGIT, kcl_pkg::CODE_EVEN_DIGIT,
     kcl_pkg::CODE_ODD_DIGIT, kcl_pkg::CODE_EVEN_DIGIT};
  logic [CODE_LEN-1:0][3:0] entry_buf = '0;
  int unsigned              norm_pos = 0;
  int unsigned              set_pos = 0;
  kcl_pkg::mode_e           cur_mode = kcl_pkg::MODE_NORMAL;
  logic [7:0]               fails = '0;
  logic                     is_locked = 1'b0;
  int unsigned              pulse_cnt = 0;
  logic                     buzz = 1'b0;
  logic                     led = 1'b0;
  logic                     relay = 1'b0;
  logic [7:0]               lim_cfg = kcl_pkg::FAIL_LIMIT_RST;
  logic [15:0]              pulse_cfg = kcl_pkg::PULSE_TICKS_RST;

  kcl_pkg::res_t lock_outputs_q[$];
  bit            failed = 1'b0;
  bit            calm = 1'b0;     // when set, neither side idles
  int unsigned   n_keys = 0;      // scan ticks sent to the lock

  // Clock: period 20
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Record one wrong entry; lock once the earlier count reaches limit minus one.
  function automatic kcl_pkg::event_e note_failure();
    kcl_pkg::event_e ev;
    ev = kcl_pkg::EV_WRONG;
    if ({1'b0, fails} + 9'd1 >= {1'b0, lim_cfg}) begin
      is_locked = 1'b1;
      relay = 1'b1;
      ev = kcl_pkg::EV_LOCKOUT;
    end
    if (fails != kcl_pkg::FAIL_SAT) fails++;
    return ev;
  endfunction

  // Advance the shadow lock by one scan tick and return the outputs it shows.
  function automatic kcl_pkg::res_t lock_step(input logic kv, input logic [3:0] kc);
    kcl_pkg::res_t   r;
    kcl_pkg::event_e ev;
    ev = kcl_pkg::EV_NONE;
    if (kv && !is_locked) begin
      if (kc <= kcl_pkg::KEY_DIGIT_MAX) begin
        if (cur_mode == kcl_pkg::MODE_NORMAL) begin
          entry_buf[norm_pos] = kc;
          norm_pos++;
          ev = kcl_pkg::EV_DIGIT;
          if (norm_pos >= CODE_LEN) begin
            if (entry_buf == code_store) begin
              buzz = 1'b1;
              pulse_cnt = 1;
              fails = '0;
              ev = kcl_pkg::EV_UNLOCK;
            end else begin
              // a wrong entry also silences the buzzer at once
              buzz = 1'b0;
              ev = note_failure();
            end
            norm_pos = 0;
          end
        end else begin
          entry_buf[set_pos] = kc;
          set_pos++;
          ev = kcl_pkg::EV_DIGIT;
          if (set_pos >= CODE_LEN) begin
            if (cur_mode == kcl_pkg::MODE_NEW) begin
              code_store = entry_buf;
              cur_mode = kcl_pkg::MODE_NORMAL;
              led = 1'b1;
              pulse_cnt = 1;
              ev = kcl_pkg::EV_CHANGED;
            end else if (entry_buf == code_store) begin
              cur_mode = kcl_pkg::MODE_NEW;
              ev = kcl_pkg::EV_OLD_OK;
            end else begin
              // stay in the old-code check
              ev = note_failure();
            end
            set_pos = 0;
          end
        end
      end else if (kc == kcl_pkg::KEY_CHANGE) begin
        // restart set mode; the normal position is kept
        cur_mode = kcl_pkg::MODE_OLD;
        set_pos = 0;
        ev = kcl_pkg::EV_SET;
      end else if (kc == kcl_pkg::KEY_CLOSE) begin
        buzz = 1'b0;
        ev = kcl_pkg::EV_SET;
      end
    end
    // The pulse timer runs on every tick, locked or not.
    if (pulse_cnt != 0) begin
      pulse_cnt++;
      if (pulse_cnt > pulse_cfg) begin
        buzz = 1'b0;
        led = 1'b0;
        pulse_cnt = 0;
      end
    end
    r.ev     = ev;
    r.digits = (cur_mode == kcl_pkg::MODE_NORMAL) ? 2'(norm_pos) : 2'(set_pos);
    r.mode   = cur_mode;
    r.fails  = fails;
    r.locked = is_locked;
    r.relay  = relay;
    r.buzzer = buzz;
    r.led    = led;
    return r;
  endfunction

  // Send one scan tick. Starts at the next falling edge, returns at the rising
  // edge of the transfer with valid still high; drain lowers it.
  task automatic send_key(input logic kv, input logic [3:0] kc);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    key_valid_i <= kv;
    key_code_i  <= kc;
    do @(posedge clk_i); while (!in_ready_o);
    n_keys++;
    lock_outputs_q.push_back(lock_step(kv, kc));
  endtask

  task automatic enter_code(input logic [3:0] d0, d1, d2, d3);
    send_key(1'b1, d0);
    send_key(1'b1, d1);
    send_key(1'b1, d2);
    send_key(1'b1, d3);
  endtask

  // Drop valid and hold until every expected result has been seen.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (lock_outputs_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_register(input logic idx, input logic [kcl_pkg::CFG_DATA_W-1:0] val);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == kcl_pkg::CFG_FAIL_LIMIT) lim_cfg = val[7:0];
    else pulse_cfg = val;
  endtask

  // Ticks without a key and keys the lock ignores.
  task automatic test_idle_keys();
    send_key(1'b0, 4'hF);
    send_key(1'b1, 4'd15);
    send_key(1'b1, 4'd12);
  endtask

  // Factory code opens the lock; close silences the buzzer.
  task automatic test_factory_unlock();
    enter_code(kcl_pkg::CODE_EVEN_DIGIT, kcl_pkg::CODE_ODD_DIGIT,
               kcl_pkg::CODE_EVEN_DIGIT, kcl_pkg::CODE_ODD_DIGIT);
    send_key(1'b1, kcl_pkg::KEY_CLOSE);
  endtask

  task automatic test_wrong_entry();
    enter_code(4'd0, 4'd9, 4'd0, 4'd9);
  endtask

  // Change code from mid-entry, miss the old code once, then store a new one.
  task automatic test_code_change();
    send_key(1'b1, 4'd5);
    send_key(1'b1, kcl_pkg::KEY_CHANGE);
    enter_code(4'd1, 4'd2, 4'd3, 4'd4);
    enter_code(code_store[0], code_store[1], code_store[2], code_store[3]);
    enter_code(4'd9, 4'd0, 4'd0, 4'd9);
    // Finish the entry left open before the change: the shared buffer
    // already holds the new code's first digit, so this opens the lock.
    send_key(1'b1, code_store[1]);
    send_key(1'b1, code_store[2]);
    send_key(1'b1, code_store[3]);
  endtask

  // Zero-length pulse ends in its own tick; the longest one outlasts the test.
  task automatic test_pulse_extremes();
    set_register(kcl_pkg::CFG_PULSE_TICKS, 16'd0);
    enter_code(code_store[0], code_store[1], code_store[2], code_store[3]);
    set_register(kcl_pkg::CFG_PULSE_TICKS, 16'hFFFF);
    enter_code(code_store[0], code_store[1], code_store[2], code_store[3]);
    send_key(1'b0, 4'd0);
    send_key(1'b1, kcl_pkg::KEY_CLOSE);
  endtask

  // Mostly well-formed entries and code changes with random content; the rest
  // close keys, single digits, bare ticks, ignored keys and lone change keys.
  // Keep the limit high enough that frequent correct entries prevent a lockout.
  task automatic test_random();
    logic [7:0]  limits[4] = '{8'd255, 8'd60, 8'd128, 8'd30};
    logic [15:0] pulses[4] = '{16'd1, 16'd5, 16'd40, 16'd300};
    int unsigned stop_at;
    int unsigned r;
    for (int ph = 0; ph < 4; ph++) begin
      set_register(kcl_pkg::CFG_FAIL_LIMIT, {8'($urandom), limits[ph]});
      set_register(kcl_pkg::CFG_PULSE_TICKS, pulses[ph]);
      stop_at = n_keys + RANDOM_PER_PHASE;
      while (n_keys < stop_at) begin
        if ($urandom_range(0, 19) == 0) calm = ~calm;
        r = $urandom_range(0, 99);
        if (r < 30) begin
          enter_code(code_store[0], code_store[1], code_store[2], code_store[3]);
        end else if (r < 42) begin
          enter_code(4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                     4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)));
        end else if (r < 60) begin
          send_key(1'b1, kcl_pkg::KEY_CHANGE);
          if ($urandom_range(0, 4) != 0)
            enter_code(code_store[0], code_store[1], code_store[2], code_store[3]);
          else
            enter_code(4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                       4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)));
          enter_code(4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                     4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)));
        end else if (r < 70) begin
          send_key(1'b1, kcl_pkg::KEY_CLOSE);
        end else if (r < 80) begin
          send_key(1'b1, 4'($urandom_range(0, 9)));
        end else if (r < 90) begin
          send_key(1'b0, 4'($urandom));
        end else if (r < 95) begin
          send_key(1'b1, 4'($urandom_range(12, 15)));
        end else begin
          send_key(1'b1, kcl_pkg::KEY_CHANGE);
        end
      end
      calm = 1'b0;
    end
  endtask

  // Zero limit locks on the first miss; afterwards every key is ignored while
  // the LED pulse still runs out. Run last: only reset clears the lock.
  task automatic test_lockout();
    set_register(kcl_pkg::CFG_PULSE_TICKS, 16'd10);
    set_register(kcl_pkg::CFG_FAIL_LIMIT, 16'd1);
    set_register(kcl_pkg::CFG_FAIL_LIMIT, 16'd0);
    send_key(1'b1, kcl_pkg::KEY_CHANGE);
    enter_code(code_store[0], code_store[1], code_store[2], code_store[3]);
    enter_code(4'd3, 4'd1, 4'd4, 4'd1);
    enter_code(4'd2, 4'd2, 4'd2, 4'd2);
    enter_code(4'd3, 4'd1, 4'd4, 4'd1);
    send_key(1'b1, kcl_pkg::KEY_CHANGE);
    send_key(1'b1, kcl_pkg::KEY_CLOSE);
    repeat (6) send_key(1'b0, 4'd0);
  endtask

  // Result side: draw a stall for each result, then hold ready until the
  // transfer.
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    kcl_pkg::res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (lock_outputs_q.size() == 0) begin
        $error("result transfer with no expectation waiting");
        failed = 1'b1;
      end else begin
        want = lock_outputs_q.pop_front();
        if (event_res_o !== want.ev) begin
          $error("event_res: expected %0d, actual %0d", want.ev, event_res_o);
          failed = 1'b1;
        end
        if (digits_entered_o !== want.digits) begin
          $error("digits_entered: expected %0d, actual %0d", want.digits, digits_entered_o);
          failed = 1'b1;
        end
        if (mode_o !== want.mode) begin
          $error("mode: expected %0d, actual %0d", want.mode, mode_o);
          failed = 1'b1;
        end
        if (fail_count_o !== want.fails) begin
          $error("fail_count: expected %0d, actual %0d", want.fails, fail_count_o);
          failed = 1'b1;
        end
        if (locked_o !== want.locked) begin
          $error("locked: expected %0d, actual %0d", want.locked, locked_o);
          failed = 1'b1;
        end
        if (relay_on_o !== want.relay) begin
          $error("relay_on: expected %0d, actual %0d", want.relay, relay_on_o);
          failed = 1'b1;
        end
        if (buzzer_on_o !== want.buzzer) begin
          $error("buzzer_on: expected %0d, actual %0d", want.buzzer, buzzer_on_o);
          failed = 1'b1;
        end
        if (led_on_o !== want.led) begin
          $error("led_on: expected %0d, actual %0d", want.led, led_on_o);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = kcl_pkg::CFG_FAIL_LIMIT;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    key_valid_i = 1'b0;
    key_code_i  = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_idle_keys();
    test_factory_unlock();
    test_wrong_entry();
    test_code_change();
    test_pulse_extremes();
    test_random();
    test_lockout();
    drain();
    repeat (3) @(posedge clk_i);

    if (!failed && lock_outputs_q.size() == 0)
      $display("All tests passed");
    else begin
      if (lock_outputs_q.size() != 0)
        $error("%0d expected results never arrived", lock_outputs_q.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/kcl_pkg.sv
design/keypad_code_lock_controller.sv
verif/tb_keypad_code_lock_controller.sv
